/* hdl/arpu_pkg.sv */
`timescale 1ns / 1ps

package arpu_pkg;

    localparam logic [6:0] FN_ABS32      = 7'd2;
    localparam logic [6:0] FN_THM_CALL   = 7'd10;
    localparam logic [6:0] FN_CALL       = 7'd28;
    localparam logic [6:0] FN_JUMP24     = 7'd29;
    localparam logic [6:0] FN_THM_JUMP24 = 7'd30;
    localparam logic [6:0] FN_MOVW       = 7'd43;
    localparam logic [6:0] FN_MOVT       = 7'd44;
    localparam logic [6:0] FN_THM_MOVW   = 7'd47;
    localparam logic [6:0] FN_THM_MOVT   = 7'd48;
    localparam logic [6:0] FN_TLS_IE32   = 7'd107;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_THUMB_RANGE = 3'd1;
    localparam logic [2:0] ST_ARM_RANGE   = 3'd2;
    localparam logic [2:0] ST_MISALIGNED  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN     = 3'd4;

    localparam logic [2:0] OP_PASS = 3'd0;
    localparam logic [2:0] OP_ABS  = 3'd1;
    localparam logic [2:0] OP_THB  = 3'd2;
    localparam logic [2:0] OP_TMOV = 3'd3;
    localparam logic [2:0] OP_AMOV = 3'd4;
    localparam logic [2:0] OP_ARB  = 3'd5;

    localparam logic [31:0] TH_BIAS = 32'h00FF_FFFF;
    localparam logic [31:0] TH_SPAN = 32'h01FF_FFFF;
    localparam logic [31:0] AR_BIAS = 32'h01FF_FFFF;
    localparam logic [31:0] AR_SPAN = 32'h03FF_FFFF;

    typedef struct packed {
        logic [2:0]  op;
        logic        top;
        logic [31:0] word;
        logic [31:0] addend;
        logic [31:0] operand;
        logic [2:0]  pre_st;
    } s1_t;

    typedef struct packed {
        logic [2:0]  op;
        logic        top;
        logic [31:0] word;
        logic [31:0] sum;
        logic [2:0]  pre_st;
    } s2_t;

endpackage

/* hdl/arm_relocation_patcher_unit.sv */
// A result is valid once its input has passed the three register stages (decode and
// offset subtract, addend add, range check and re-pack), which all advance together.
// Throughput: one relocation per cycle while the output is not stalled.
// A stall on the output holds all three stages and raises in_stall in the same cycle.
// Reset (rst_n, asynchronous, active low) clears the stage valid bits only.
`timescale 1ns / 1ps

module arm_relocation_patcher_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [6:0]  func,
    input  logic [31:0] insn_word,
    input  logic [31:0] symbol_address,
    input  logic [31:0] place_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] patched_word,
    output logic [2:0]  status
);

    logic          advance;
    logic          s1_valid;
    logic          s2_valid;
    arpu_pkg::s1_t s1;
    arpu_pkg::s2_t s2;

    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    arpu_decode u_decode
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (advance),
        .in_valid       (in_valid),
        .func           (func),
        .insn_word      (insn_word),
        .symbol_address (symbol_address),
        .place_address  (place_address),
        .s1_valid       (s1_valid),
        .s1             (s1)
    );

    arpu_add u_add
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .s1_valid (s1_valid),
        .s1       (s1),
        .s2_valid (s2_valid),
        .s2       (s2)
    );

    arpu_pack u_pack
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .s2_valid     (s2_valid),
        .s2           (s2),
        .out_valid    (out_valid),
        .patched_word (patched_word),
        .status       (status)
    );

endmodule

/* hdl/arpu_decode.sv */
`timescale 1ns / 1ps

module arpu_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [6:0]         func,
    input  logic [31:0]        insn_word,
    input  logic [31:0]        symbol_address,
    input  logic [31:0]        place_address,
    output logic               s1_valid,
    output arpu_pkg::s1_t      s1
);

    logic          valid_reg;
    arpu_pkg::s1_t data_reg;
    arpu_pkg::s1_t data_next;
    logic [24:0]   thb_off;
    logic [15:0]   tmov_imm;
    logic [15:0]   amov_imm;
    logic [31:0]   delta;

    assign delta = symbol_address - place_address;

    assign thb_off = {insn_word[10], ~(insn_word[29] ^ insn_word[10]),
                      ~(insn_word[27] ^ insn_word[10]), insn_word[9:0],
                      insn_word[26:16], 1'b0};
    assign tmov_imm = {insn_word[3:0], insn_word[10], insn_word[30:28], insn_word[23:16]};
    assign amov_imm = {insn_word[19:16], insn_word[11:0]};

    always_comb
    begin
        data_next.op      = arpu_pkg::OP_PASS;
        data_next.top     = 1'b0;
        data_next.word    = insn_word;
        data_next.addend  = 32'd0;
        data_next.operand = symbol_address;
        data_next.pre_st  = arpu_pkg::ST_OK;
        unique case (func) inside
            arpu_pkg::FN_ABS32:
            begin
                data_next.op     = arpu_pkg::OP_ABS;
                data_next.addend = insn_word;
            end
            arpu_pkg::FN_THM_CALL, arpu_pkg::FN_THM_JUMP24:
            begin
                data_next.op      = arpu_pkg::OP_THB;
                data_next.addend  = {{7{thb_off[24]}}, thb_off};
                data_next.operand = delta;
            end
            arpu_pkg::FN_THM_MOVW, arpu_pkg::FN_THM_MOVT:
            begin
                data_next.op     = arpu_pkg::OP_TMOV;
                data_next.top    = (func == arpu_pkg::FN_THM_MOVT);
                data_next.addend = {{16{tmov_imm[15]}}, tmov_imm};
            end
            arpu_pkg::FN_MOVW, arpu_pkg::FN_MOVT:
            begin
                data_next.op     = arpu_pkg::OP_AMOV;
                data_next.top    = (func == arpu_pkg::FN_MOVT);
                data_next.addend = {{16{amov_imm[15]}}, amov_imm};
            end
            arpu_pkg::FN_CALL, arpu_pkg::FN_JUMP24:
            begin
                data_next.op      = arpu_pkg::OP_ARB;
                data_next.addend  = {{6{insn_word[23]}}, insn_word[23:0], 2'b00};
                data_next.operand = delta;
                if (symbol_address[1:0] != 2'b00)
                begin
                    data_next.pre_st = arpu_pkg::ST_MISALIGNED;
                end
            end
            arpu_pkg::FN_TLS_IE32:
            begin
                data_next.op = arpu_pkg::OP_PASS;
            end
            default:
            begin
                data_next.pre_st = arpu_pkg::ST_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1       = data_reg;

endmodule

/* hdl/arpu_add.sv */
`timescale 1ns / 1ps

module arpu_add
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          s1_valid,
    input  arpu_pkg::s1_t s1,
    output logic          s2_valid,
    output arpu_pkg::s2_t s2
);

    logic          valid_reg;
    arpu_pkg::s2_t data_reg;
    arpu_pkg::s2_t data_next;

    always_comb
    begin
        data_next.op     = s1.op;
        data_next.top    = s1.top;
        data_next.word   = s1.word;
        data_next.sum    = s1.addend + s1.operand;
        data_next.pre_st = s1.pre_st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign s2_valid = valid_reg;
    assign s2       = data_reg;

endmodule

/* hdl/arpu_pack.sv */
`timescale 1ns / 1ps

module arpu_pack
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          s2_valid,
    input  arpu_pkg::s2_t s2,
    output logic          out_valid,
    output logic [31:0]   patched_word,
    output logic [2:0]    status
);

    logic        valid_reg;
    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic [2:0]  status_reg;
    logic [2:0]  status_next;
    logic [31:0] thb_chk;
    logic [31:0] arb_chk;
    logic [15:0] half;
    logic [31:0] w;
    logic [31:0] off;
    logic        s;

    assign w       = s2.word;
    assign off     = s2.sum;
    assign s       = off[24];
    assign half    = s2.top ? off[31:16] : off[15:0];
    assign thb_chk = off + arpu_pkg::TH_BIAS;
    assign arb_chk = off + arpu_pkg::AR_BIAS;

    always_comb
    begin
        word_next   = w;
        status_next = s2.pre_st;
        case (s2.op)
            arpu_pkg::OP_ABS:
            begin
                word_next = off;
            end
            arpu_pkg::OP_THB:
            begin
                if (thb_chk >= arpu_pkg::TH_SPAN)
                begin
                    status_next = arpu_pkg::ST_THUMB_RANGE;
                end
                else
                begin
                    word_next = {w[31:30], s ^ ~off[23], w[28], s ^ ~off[22], off[11:1],
                                 w[15:11], s, off[21:12]};
                end
            end
            arpu_pkg::OP_TMOV:
            begin
                word_next = {w[31], half[10:8], w[27:24], half[7:0],
                             w[15:11], half[11], w[9:4], half[15:12]};
            end
            arpu_pkg::OP_AMOV:
            begin
                word_next = {w[31:20], half[15:12], w[15:12], half[11:0]};
            end
            arpu_pkg::OP_ARB:
            begin
                if (s2.pre_st == arpu_pkg::ST_OK)
                begin
                    if (arb_chk >= arpu_pkg::AR_SPAN)
                    begin
                        status_next = arpu_pkg::ST_ARM_RANGE;
                    end
                    else
                    begin
                        word_next = {w[31:24], off[25:2]};
                    end
                end
            end
            default:
            begin
                word_next = w;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg   <= word_next;
            status_reg <= status_next;
        end
    end

    assign out_valid    = valid_reg;
    assign patched_word = word_reg;
    assign status       = status_reg;

endmodule

/* hdl/arpu_checker.sv */
`timescale 1ns / 1ps

module arpu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] patched_word,
    input logic [2:0]  status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(patched_word) && $stable(status))
        else $error("Stalled result changed or was dropped.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("Input stalled while the output was free.");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !(out_valid && out_stall) ##1 !(out_valid && out_stall)
        |=> out_valid)
        else $error("Accepted transfer did not reach the output in three cycles.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= arpu_pkg::ST_UNKNOWN)
        else $error("Result carries an undefined status code.");

endmodule

bind arm_relocation_patcher_unit arpu_checker u_arpu_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .patched_word (patched_word),
    .status       (status)
);

/* sim/arm_relocation_patcher_unit_tb.sv */
`timescale 1ns / 1ps

module arm_relocation_patcher_unit_tb;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  st;
    } patch_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [6:0]  func = '0;
    logic [31:0] insn_word = '0;
    logic [31:0] symbol_address = '0;
    logic [31:0] place_address = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] patched_word;
    logic [2:0]  status;

    patch_t expected_patches[$];
    int     error_count = 0;
    bit     gaps_on = 1'b1;
    bit     stall_on = 1'b1;
    int     stall_left = 0;

    arm_relocation_patcher_unit i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .insn_word      (insn_word),
        .symbol_address (symbol_address),
        .place_address  (place_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .patched_word   (patched_word),
        .status         (status)
    );

    always #2 clk = ~clk;

    initial
    begin
        #(2_000_000);
        $display("arm_relocation_patcher_unit verification failed");
        $finish;
    end

    function automatic logic [31:0] sext_imm16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic patch_t compute_relocation(input logic [6:0] fn, input logic [31:0] w,
                                                  input logic [31:0] sym,
                                                  input logic [31:0] place);
        patch_t      r;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [31:0] off;
        logic [31:0] v;
        logic        s;
        logic        j1;
        logic        j2;
        r.word = w;
        r.st = arpu_pkg::ST_OK;
        hi = w[15:0];
        lo = w[31:16];
        case (fn)
            arpu_pkg::FN_ABS32:
            begin
                r.word = w + sym;
            end
            arpu_pkg::FN_THM_CALL, arpu_pkg::FN_THM_JUMP24:
            begin
                s = hi[10];
                off = {{7{s}}, s, ~(lo[13] ^ s), ~(lo[11] ^ s), hi[9:0], lo[10:0], 1'b0};
                off = off + sym - place;
                if (off + arpu_pkg::TH_BIAS >= arpu_pkg::TH_SPAN)
                begin
                    r.st = arpu_pkg::ST_THUMB_RANGE;
                end
                else
                begin
                    s = off[24];
                    j1 = s ^ ~off[23];
                    j2 = s ^ ~off[22];
                    r.word = {lo[15:14], j1, lo[12], j2, off[11:1],
                              hi[15:11], s, off[21:12]};
                end
            end
            arpu_pkg::FN_THM_MOVW, arpu_pkg::FN_THM_MOVT:
            begin
                v = sext_imm16({hi[3:0], hi[10], lo[14:12], lo[7:0]}) + sym;
                if (fn == arpu_pkg::FN_THM_MOVT)
                begin
                    v = v >> 16;
                end
                r.word = {lo[15], v[10:8], lo[11:8], v[7:0], hi[15:11], v[11], hi[9:4], v[15:12]};
            end
            arpu_pkg::FN_MOVW, arpu_pkg::FN_MOVT:
            begin
                v = sext_imm16({w[19:16], w[11:0]}) + sym;
                if (fn == arpu_pkg::FN_MOVT)
                begin
                    v = v >> 16;
                end
                r.word = {w[31:20], v[15:12], w[15:12], v[11:0]};
            end
            arpu_pkg::FN_CALL, arpu_pkg::FN_JUMP24:
            begin
                if (sym[1:0] != 2'b00)
                begin
                    r.st = arpu_pkg::ST_MISALIGNED;
                end
                else
                begin
                    off = {{6{w[23]}}, w[23:0], 2'b00} + sym - place;
                    if (off + arpu_pkg::AR_BIAS >= arpu_pkg::AR_SPAN)
                    begin
                        r.st = arpu_pkg::ST_ARM_RANGE;
                    end
                    else
                    begin
                        r.word = {w[31:24], off[25:2]};
                    end
                end
            end
            arpu_pkg::FN_TLS_IE32:
            begin
                r.word = w;
            end
            default:
            begin
                r.st = arpu_pkg::ST_UNKNOWN;
            end
        endcase
        return r;
    endfunction

    function automatic logic [6:0] known_kind(input int idx);
        case (idx)
            0: return arpu_pkg::FN_ABS32;
            1: return arpu_pkg::FN_THM_CALL;
            2: return arpu_pkg::FN_CALL;
            3: return arpu_pkg::FN_JUMP24;
            4: return arpu_pkg::FN_THM_JUMP24;
            5: return arpu_pkg::FN_MOVW;
            6: return arpu_pkg::FN_MOVT;
            7: return arpu_pkg::FN_THM_MOVW;
            8: return arpu_pkg::FN_THM_MOVT;
            default: return arpu_pkg::FN_TLS_IE32;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 65)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 100)
        begin
            $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        end
        error_count++;
    endtask

    // Called and returns at a falling edge; valid stays high between back-to-back transfers.
    task automatic send_item(input logic [6:0] fn, input logic [31:0] w,
                             input logic [31:0] sym, input logic [31:0] place);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        func = fn;
        insn_word = w;
        symbol_address = sym;
        place_address = place;
        do
            @(posedge clk);
        while (in_stall);
        expected_patches.push_back(compute_relocation(fn, w, sym, place));
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid = 1'b0;
        while (expected_patches.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_random();
        logic [6:0]  fn;
        logic [31:0] w;
        logic [31:0] sym;
        logic [31:0] place;
        logic [31:0] delta;
        int          pick;
        pick = $urandom_range(0, 99);
        w = $urandom;
        sym = $urandom;
        place = $urandom;
        if (pick < 8)
        begin
            fn = 7'($urandom_range(0, 127));
        end
        else
        begin
            fn = known_kind($urandom_range(0, 9));
        end
        // Branch targets mostly land near the place so that the range checks are exercised
        // on both sides of their limits.
        if ((fn == arpu_pkg::FN_THM_CALL || fn == arpu_pkg::FN_THM_JUMP24
             || fn == arpu_pkg::FN_CALL || fn == arpu_pkg::FN_JUMP24)
            && $urandom_range(0, 9) < 8)
        begin
            case ($urandom_range(0, 3))
                0: delta = $urandom & 32'h0000_0FFF;
                1: delta = $urandom & 32'h000F_FFFF;
                2: delta = $urandom & 32'h01FF_FFFF;
                default: delta = $urandom & 32'h03FF_FFFF;
            endcase
            if ($urandom_range(0, 1) == 1)
            begin
                delta = -delta;
            end
            sym = place + delta;
            if ((fn == arpu_pkg::FN_CALL || fn == arpu_pkg::FN_JUMP24)
                && $urandom_range(0, 99) < 85)
            begin
                sym[1:0] = 2'b00;
            end
        end
        send_item(fn, w, sym, place);
    endtask

    task automatic test_directed();
        send_item(arpu_pkg::FN_ABS32, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_item(arpu_pkg::FN_ABS32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(arpu_pkg::FN_THM_CALL, 32'hF800_F000, 32'h0100_0FFF, 32'h0000_1000);
        send_item(arpu_pkg::FN_THM_CALL, 32'hF800_F000, 32'h0100_1000, 32'h0000_1000);
        send_item(arpu_pkg::FN_THM_JUMP24, 32'hB800_F000, 32'h0100_0001, 32'h0200_0000);
        send_item(arpu_pkg::FN_THM_JUMP24, 32'hB800_F000, 32'h0100_0000, 32'h0200_0000);
        send_item(arpu_pkg::FN_THM_CALL, 32'hD7FF_F3FF, 32'h0000_4000, 32'h0000_4000);
        send_item(arpu_pkg::FN_THM_CALL, 32'hD000_F400, 32'h0000_4000, 32'h0000_4000);
        send_item(arpu_pkg::FN_THM_JUMP24, 32'hD000_F400, 32'h0000_4002, 32'h0000_4000);
        send_item(arpu_pkg::FN_CALL, 32'hEB00_0000, 32'h0200_0000, 32'h0000_0001);
        send_item(arpu_pkg::FN_CALL, 32'hEB00_0000, 32'h0200_0000, 32'h0000_0000);
        send_item(arpu_pkg::FN_JUMP24, 32'hEA00_0000, 32'h0000_0000, 32'h01FF_FFFF);
        send_item(arpu_pkg::FN_JUMP24, 32'hEA00_0000, 32'h0000_0000, 32'h0200_0000);
        send_item(arpu_pkg::FN_CALL, 32'hEBFF_FFFE, 32'h0000_8001, 32'h0000_8000);
        send_item(arpu_pkg::FN_JUMP24, 32'hEA7F_FFFF, 32'h0000_1003, 32'h0000_1000);
        send_item(arpu_pkg::FN_JUMP24, 32'hEAFF_FFFE, 32'h0000_8000, 32'h0000_8008);
        send_item(arpu_pkg::FN_MOVW, 32'hE30F_0FFF, 32'h1234_5678, 32'h0000_0000);
        send_item(arpu_pkg::FN_MOVT, 32'hE340_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(arpu_pkg::FN_MOVT, 32'hE347_0FFF, 32'h8000_0000, 32'h0000_0000);
        send_item(arpu_pkg::FN_THM_MOVW, 32'h70FF_F64F, 32'h0000_0001, 32'h0000_0000);
        send_item(arpu_pkg::FN_THM_MOVT, 32'h0000_F2C0, 32'hDEAD_BEEF, 32'h0000_0000);
        send_item(arpu_pkg::FN_THM_MOVW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(arpu_pkg::FN_TLS_IE32, 32'hA5A5_5A5A, 32'h1234_5678, 32'h9ABC_DEF0);
        send_item(7'd0, 32'h1357_9BDF, 32'h0000_0004, 32'h0000_0000);
        send_item(7'd127, 32'hFFFF_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_mix();
        repeat (500)
        begin
            send_random();
        end
    endtask

    task automatic test_full_rate();
        gaps_on = 1'b0;
        stall_on = 1'b0;
        repeat (120)
        begin
            send_random();
        end
        gaps_on = 1'b1;
        stall_on = 1'b1;
    endtask

    task automatic test_drain_pauses();
        repeat (5)
        begin
            repeat (20)
            begin
                send_random();
            end
            wait_for_results();
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left == 0 && stall_on)
        begin : pick_stall
            int r;
            r = $urandom_range(0, 99);
            if (r >= 95)
            begin
                stall_left = $urandom_range(10, 40);
            end
            else if (r >= 70)
            begin
                stall_left = $urandom_range(1, 3);
            end
        end
        if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin : check_result
            patch_t want;
            if (expected_patches.size() == 0)
            begin
                report_mismatch("unexpected transfer", patched_word, 32'h0);
            end
            else
            begin
                want = expected_patches.pop_front();
                if (patched_word !== want.word)
                begin
                    report_mismatch("patched_word", patched_word, want.word);
                end
                if (status !== want.st)
                begin
                    report_mismatch("status", {29'd0, status}, {29'd0, want.st});
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_mix();
        test_full_rate();
        test_drain_pauses();
        wait_for_results();
        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("arm_relocation_patcher_unit verification clean");
        end
        else
        begin
            $display("arm_relocation_patcher_unit verification failed");
        end
        $finish;
    end

endmodule
